@@ rtl/core/pidq_pkg.sv @@
`default_nettype none

package pidq_pkg;

    localparam int Q_SHIFT = 16;
    localparam int CFG_DATA_W = 64;
    localparam int PIPE_DEPTH = 4;
    localparam logic [63:0] LIMITS_RESET = 64'h7FFF_FFFF_8000_0000;

    typedef enum logic [2:0] {
        REG_KP_GAIN    = 3'd0,
        REG_KI_GAIN    = 3'd1,
        REG_KD_GAIN    = 3'd2,
        REG_P_LIMITS   = 3'd3,
        REG_I_LIMITS   = 3'd4,
        REG_D_LIMITS   = 3'd5,
        REG_OUT_LIMITS = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] kp_gain;
        logic signed [31:0] ki_gain;
        logic signed [31:0] kd_gain;
        logic [63:0]        p_limits;
        logic [63:0]        i_limits;
        logic [63:0]        d_limits;
        logic [63:0]        out_limits;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] p_term;
        logic signed [31:0] i_term;
        logic signed [31:0] d_term;
    } terms_t;

    // max test first, then min; limits packed max high, min low
    function automatic logic signed [31:0] clamp32(input logic signed [65:0] x,
                                                   input logic [63:0] lim);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        logic signed [31:0] res;
        hi = {{34{lim[63]}}, lim[63:32]};
        lo = {{34{lim[31]}}, lim[31:0]};
        if (x > hi)
        begin
            res = lim[63:32];
        end
        else if (x < lo)
        begin
            res = lim[31:0];
        end
        else
        begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pidq_ifs.sv @@
`default_nettype none

interface pidq_err_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink (input valid, input error_sample, output ready);
endinterface

interface pidq_drive_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pidq_cfg.sv @@
`default_nettype none

module pidq_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire pidq_pkg::reg_index_t               cfg_index,
    input  wire logic [pidq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pidq_pkg::cfg_t                          cfg
);
    import pidq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP_GAIN:    cfg_next.kp_gain = cfg_data[31:0];
                REG_KI_GAIN:    cfg_next.ki_gain = cfg_data[31:0];
                REG_KD_GAIN:    cfg_next.kd_gain = cfg_data[31:0];
                REG_P_LIMITS:   cfg_next.p_limits = cfg_data;
                REG_I_LIMITS:   cfg_next.i_limits = cfg_data;
                REG_D_LIMITS:   cfg_next.d_limits = cfg_data;
                REG_OUT_LIMITS: cfg_next.out_limits = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain    <= '0;
            cfg_reg.ki_gain    <= '0;
            cfg_reg.kd_gain    <= '0;
            cfg_reg.p_limits   <= LIMITS_RESET;
            cfg_reg.i_limits   <= LIMITS_RESET;
            cfg_reg.d_limits   <= LIMITS_RESET;
            cfg_reg.out_limits <= LIMITS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/pidq_terms.sv @@
`default_nettype none

module pidq_terms (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pidq_pkg::cfg_t cfg,
    pidq_err_if.sink            sample,
    output pidq_pkg::terms_t    terms,
    output logic                terms_valid,
    input  wire logic           terms_ready
);
    import pidq_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic signed [31:0] err_reg;
    logic               terms_valid_reg;
    logic               terms_valid_next;
    terms_t             terms_reg;
    terms_t             terms_next;
    logic signed [31:0] prior_reg;
    logic signed [31:0] prior_next;
    logic signed [31:0] integral_reg;
    logic signed [31:0] integral_next;

    logic               adv_in;
    logic               adv_terms;
    logic               take;
    logic signed [65:0] err_wide;
    logic signed [65:0] isum_wide;
    logic signed [65:0] diff_wide;
    logic signed [31:0] isum_clamped;

    assign adv_terms = !terms_valid_reg || terms_ready;
    assign adv_in    = !in_valid_reg || adv_terms;
    assign take      = adv_terms && in_valid_reg;

    assign sample.ready = adv_in;

    // running sum and difference kept wide so nothing wraps before the clamp
    always_comb
    begin
        err_wide     = {{34{err_reg[31]}}, err_reg};
        isum_wide    = {{34{integral_reg[31]}}, integral_reg} + err_wide;
        diff_wide    = err_wide - {{34{prior_reg[31]}}, prior_reg};
        isum_clamped = clamp32(isum_wide, cfg.i_limits);

        in_valid_next    = adv_in ? sample.valid : in_valid_reg;
        terms_valid_next = adv_terms ? in_valid_reg : terms_valid_reg;
        terms_next       = terms_reg;
        prior_next       = prior_reg;
        integral_next    = integral_reg;
        if (take)
        begin
            terms_next.p_term = clamp32(err_wide, cfg.p_limits);
            terms_next.i_term = isum_clamped;
            terms_next.d_term = clamp32(diff_wide, cfg.d_limits);
            prior_next        = err_reg;
            integral_next     = isum_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            terms_valid_reg <= 1'b0;
            prior_reg       <= '0;
            integral_reg    <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            terms_valid_reg <= terms_valid_next;
            prior_reg       <= prior_next;
            integral_reg    <= integral_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && sample.valid)
        begin
            err_reg <= sample.error_sample;
        end
        terms_reg <= terms_next;
    end

    assign terms       = terms_reg;
    assign terms_valid = terms_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/pidq_mac.sv @@
`default_nettype none

module pidq_mac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pidq_pkg::cfg_t  cfg,
    input  wire pidq_pkg::terms_t terms,
    input  wire logic            terms_valid,
    output logic                 terms_ready,
    pidq_drive_if.source         result
);
    import pidq_pkg::*;

    logic               prod_valid_reg;
    logic               prod_valid_next;
    logic signed [63:0] prod_p_reg;
    logic signed [63:0] prod_i_reg;
    logic signed [63:0] prod_d_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] drive_reg;

    logic               adv_prod;
    logic               adv_out;
    logic signed [63:0] prod_p;
    logic signed [63:0] prod_i;
    logic signed [63:0] prod_d;
    logic signed [65:0] sum_wide;
    logic signed [65:0] sum_shifted;

    assign adv_out  = !out_valid_reg || result.ready;
    assign adv_prod = !prod_valid_reg || adv_out;

    assign terms_ready = adv_prod;

    assign prod_p = cfg.kp_gain * terms.p_term;
    assign prod_i = cfg.ki_gain * terms.i_term;
    assign prod_d = cfg.kd_gain * terms.d_term;

    // exact sum of the three products, then floor shift
    always_comb
    begin
        sum_wide = {{2{prod_p_reg[63]}}, prod_p_reg}
                 + {{2{prod_i_reg[63]}}, prod_i_reg}
                 + {{2{prod_d_reg[63]}}, prod_d_reg};
        sum_shifted     = sum_wide >>> Q_SHIFT;
        prod_valid_next = adv_prod ? terms_valid : prod_valid_reg;
        out_valid_next  = adv_out ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_prod && terms_valid)
        begin
            prod_p_reg <= prod_p;
            prod_i_reg <= prod_i;
            prod_d_reg <= prod_d;
        end
        if (adv_out && prod_valid_reg)
        begin
            drive_reg <= clamp32(sum_shifted, cfg.out_limits);
        end
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

endmodule

`default_nettype wire

@@ rtl/core/pid_controller_q16.sv @@
// an accepted error word passes the input, terms, product and drive registers
// throughput: one word per cycle unless result.ready stalls, set by the
// combinational add-and-clamp of the integral sum and the multiplier stage
// reset: rst_n clears all valid flags, gains to zero, limits to full range,
// prior error and integral sum to zero; no clearing pass
`default_nettype none

module pid_controller_q16 (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire pidq_pkg::reg_index_t            cfg_index,
    input  wire logic [pidq_pkg::CFG_DATA_W-1:0] cfg_data,
    pidq_err_if.sink                             sample,
    pidq_drive_if.source                         result
);
    import pidq_pkg::*;

    cfg_t   cfg;
    terms_t terms;
    logic   terms_valid;
    logic   terms_ready;

    pidq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidq_terms u_terms (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .sample      (sample),
        .terms       (terms),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready)
    );

    pidq_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .terms       (terms),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .result      (result)
    );

endmodule

`default_nettype wire

@@ rtl/core/pidq_checker.sv @@
`default_nettype none

module pidq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_drive
);
    import pidq_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // words in flight
    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("drive word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_drive))
        else $error("drive word changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("drive word without an error word in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(PIPE_DEPTH) |-> in_ready)
        else $error("input stalled with a free stage");

endmodule

bind pid_controller_q16 pidq_checker u_pidq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_drive (result.drive)
);

`default_nettype wire
